>>> sv/cnt_pkg.sv
// shared types and codes for the conditional nesting tracker
package cnt_pkg;

    // directive codes carried in the request
    typedef enum logic [2:0] {
        OP_IF     = 3'd0,
        OP_IFDEF  = 3'd1,
        OP_ELIF   = 3'd2,
        OP_ELSE   = 3'd3,
        OP_ENDIF  = 3'd4
    } op_t;

    // error codes returned with each result
    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_TOO_DEEP  = 3'd1,
        ERR_ORPHAN_ELIF = 3'd2,
        ERR_ORPHAN_ELSE = 3'd3,
        ERR_EXTRA_ENDIF = 3'd4
    } err_t;

    localparam int unsigned DEPTH_OUT_W = 6;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 16;

    // one saved conditional frame
    typedef struct packed {
        logic taken;    // an alternative of this chain was already chosen
        logic else_ok;  // enclosing level allowed elif/else
        logic active;   // enclosing text was active
    } frame_t;

    // commands from the control logic to the frame stack
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   set_taken;
        frame_t new_frame;
    } stack_cmd_t;

    // one result item
    typedef struct packed {
        err_t                   error_code;
        logic [DEPTH_OUT_W-1:0] depth;
        logic                   active;
    } result_t;

endpackage

>>> sv/conditional_nesting_tracker.sv
// top level of the conditional nesting tracker
//
// Follows nested conditional-compilation directives. Each request on the
// s_axis channel is one directive (if, ifdef/ifndef, elif, else, endif) with
// its condition already evaluated; each request gives exactly one result on
// the m_axis channel: the active flag, the nesting depth and an error code.
// A directive that raises an error leaves the nesting state untouched.
//
// The result is registered and appears in the cycle after its request is
// accepted. Throughput is one request per cycle while m_axis_tready is high;
// the next-state logic reads only the top frame, which sits in a register, and
// the frames below it live in a memory that refills the top register on a pop.
//
// Reset clears the depth to zero, marks text active and forbids elif/else.
// The result register holds one result; while the receiver stalls it keeps
// that result and s_axis_tready stays low until it is taken, and a new
// request is taken in the same cycle the waiting result leaves.
module conditional_nesting_tracker
    import cnt_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // operation[2:0], condition[3], macro_defined[4], want_defined[5], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // active[0], depth[6:1], error_code[9:7], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    logic          accept;
    logic [DW-1:0] depth;
    stack_cmd_t    cmd;
    frame_t        top_frame;
    result_t       result;
    result_t       out_data_reg;
    logic          out_valid_reg;
    logic          out_valid_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cnt_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (s_axis_tdata[2:0]),
        .condition     (s_axis_tdata[3]),
        .macro_defined (s_axis_tdata[4]),
        .want_defined  (s_axis_tdata[5]),
        .top_frame     (top_frame),
        .depth         (depth),
        .cmd           (cmd),
        .result        (result)
    );

    cnt_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .cmd       (cmd),
        .depth     (depth),
        .top_frame (top_frame)
    );

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_data_reg};

endmodule

>>> sv/cnt_stack.sv
// frame stack: top frame in a register, frames below it in a memory
module cnt_stack
    import cnt_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32,
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1),
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
)
(
    input  logic          clk,
    input  stack_cmd_t    cmd,
    input  logic [DW-1:0] depth,
    output frame_t        top_frame
);

    frame_t        frame_mem [STACK_DEPTH];
    frame_t        top_frame_reg;
    logic [DW-1:0] below_top;
    logic [DW-1:0] top_index;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // addresses of the top entry and of the one under it
    assign top_index = depth - DW'(1);
    assign below_top = depth - DW'(2);
    assign wr_addr   = top_index[AW-1:0];
    assign rd_addr   = below_top[AW-1:0];

    // spill the old top frame into memory on a push
    always_ff @(posedge clk)
    begin
        if (cmd.push && (depth != '0))
        begin
            frame_mem[wr_addr] <= top_frame_reg;
        end
    end

    // top frame register: new frame on a push, refilled from memory on a pop, marked taken on set_taken
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            top_frame_reg <= cmd.new_frame;
        end
        else if (cmd.pop)
        begin
            top_frame_reg <= frame_mem[rd_addr];
        end
        else if (cmd.set_taken)
        begin
            top_frame_reg.taken <= 1'b1;
        end
    end

    assign top_frame = top_frame_reg;

endmodule

>>> sv/cnt_core.sv
// directive decode, nesting state and next result
module cnt_core
    import cnt_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32,
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [2:0]    operation,
    input  logic          condition,
    input  logic          macro_defined,
    input  logic          want_defined,
    input  frame_t        top_frame,
    output logic [DW-1:0] depth,
    output stack_cmd_t    cmd,
    output result_t       result
);

    logic [DW-1:0]          depth_reg;
    logic [DW-1:0]          depth_next;
    logic                   else_ok_reg;
    logic                   else_ok_next;
    logic                   proc_reg;
    logic                   proc_next;
    err_t                   err;
    logic                   branch_value;
    logic                   chain_open;
    logic [DW+DEPTH_OUT_W-1:0] depth_wide;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            else_ok_reg <= 1'b0;
            proc_reg    <= 1'b1;
        end
        else if (accept)
        begin
            depth_reg   <= depth_next;
            else_ok_reg <= else_ok_next;
            proc_reg    <= proc_next;
        end
    end

    // value of the branch opened by if or ifdef/ifndef
    assign branch_value = (op_t'(operation) == OP_IF) ? condition
                                                      : (want_defined == macro_defined);
    assign chain_open   = else_ok_reg && (depth_reg != '0);

    // next state per directive
    always_comb
    begin
        depth_next    = depth_reg;
        else_ok_next  = else_ok_reg;
        proc_next     = proc_reg;
        err           = ERR_OK;
        cmd.push      = 1'b0;
        cmd.pop       = 1'b0;
        cmd.set_taken = 1'b0;
        cmd.new_frame.active  = proc_reg;
        cmd.new_frame.else_ok = else_ok_reg;
        cmd.new_frame.taken   = proc_reg && branch_value;
        case (op_t'(operation))
            OP_IF, OP_IFDEF:
            begin
                if (depth_reg == DW'(STACK_DEPTH))
                begin
                    err = ERR_TOO_DEEP;
                end
                else
                begin
                    cmd.push     = accept;
                    depth_next   = depth_reg + DW'(1);
                    else_ok_next = 1'b1;
                    proc_next    = proc_reg && branch_value;
                end
            end
            OP_ELIF:
            begin
                if (!chain_open)
                begin
                    err = ERR_ORPHAN_ELIF;
                end
                else if (top_frame.active && !top_frame.taken)
                begin
                    proc_next     = condition;
                    cmd.set_taken = accept && condition;
                end
                else
                begin
                    proc_next = 1'b0;
                end
            end
            OP_ELSE:
            begin
                if (!chain_open)
                begin
                    err = ERR_ORPHAN_ELSE;
                end
                else
                begin
                    proc_next    = top_frame.active && !top_frame.taken;
                    else_ok_next = 1'b0;
                end
            end
            OP_ENDIF:
            begin
                if (depth_reg == '0)
                begin
                    err = ERR_EXTRA_ENDIF;
                end
                else
                begin
                    cmd.pop      = accept;
                    depth_next   = depth_reg - DW'(1);
                    proc_next    = top_frame.active;
                    else_ok_next = top_frame.else_ok;
                end
            end
            default:
            begin
                err = ERR_OK;
            end
        endcase
    end

    // result: depth reported modulo 64
    assign depth_wide        = {{DEPTH_OUT_W{1'b0}}, depth_next};
    assign result.active     = proc_next;
    assign result.depth      = depth_wide[DEPTH_OUT_W-1:0];
    assign result.error_code = err;
    assign depth             = depth_reg;

endmodule

>>> sv/cnt_checker.sv
// port-level checks for the conditional nesting tracker, bound to the top
module cnt_checker
    import cnt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // with the result register empty a request is always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused with empty result register");

    // every accepted request leaves a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    // a result never appears without a request accepted just before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without request");

    // a result never reports an unknown error code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:7] == ERR_OK
                        || m_axis_tdata[9:7] == ERR_TOO_DEEP
                        || m_axis_tdata[9:7] == ERR_ORPHAN_ELIF
                        || m_axis_tdata[9:7] == ERR_ORPHAN_ELSE
                        || m_axis_tdata[9:7] == ERR_EXTRA_ENDIF))
        else $error("unknown error code");

endmodule

bind conditional_nesting_tracker cnt_checker u_cnt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/tb_conditional_nesting_tracker.sv
// self-checking testbench for the conditional nesting tracker
`timescale 1ns / 1ps

module tb_conditional_nesting_tracker;
    import cnt_pkg::*;

    localparam int unsigned STACK_DEPTH  = 32;
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned LONG_HOLD    = 60;
    localparam int unsigned SETTLE_TICKS = 4;

    // operation codes outside the directive set, ignored by the block
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    // predicts the directive outcome and holds the results still owed
    class nesting_scoreboard;
        frame_t      frames [STACK_DEPTH];
        int unsigned open_count;
        bit          else_ok;
        bit          text_active;
        result_t     owed_results [$];
        int unsigned failures;

        function new();
            open_count  = 0;
            else_ok     = 1'b0;
            text_active = 1'b1;
            failures    = 0;
        endfunction

        // push a frame for if/ifdef/ifndef
        function err_t open_level(bit branch);
            frame_t fr;
            if (open_count >= STACK_DEPTH)
                return ERR_TOO_DEEP;
            fr         = '0;
            fr.else_ok = else_ok;
            if (text_active)
            begin
                fr.active   = 1'b1;
                fr.taken    = branch;
                text_active = branch;
            end
            frames[open_count] = fr;
            open_count++;
            else_ok = 1'b1;
            return ERR_OK;
        endfunction

        // update the nesting state for one accepted request
        function void note_directive(logic [2:0] op, bit cond, bit defd, bit polarity);
            err_t        err;
            result_t     res;
            int unsigned t;
            err = ERR_OK;
            case (op)
                OP_IF:    err = open_level(cond);
                OP_IFDEF: err = open_level(polarity == defd);
                OP_ELIF:
                begin
                    if (!else_ok || open_count == 0)
                        err = ERR_ORPHAN_ELIF;
                    else
                    begin
                        t = open_count - 1;
                        if (frames[t].active && !frames[t].taken)
                        begin
                            if (cond)
                                frames[t].taken = 1'b1;
                            text_active = cond;
                        end
                        else
                            text_active = 1'b0;
                    end
                end
                OP_ELSE:
                begin
                    if (!else_ok || open_count == 0)
                        err = ERR_ORPHAN_ELSE;
                    else
                    begin
                        t = open_count - 1;
                        text_active = frames[t].active && !frames[t].taken;
                        else_ok = 1'b0;
                    end
                end
                OP_ENDIF:
                begin
                    if (open_count == 0)
                        err = ERR_EXTRA_ENDIF;
                    else
                    begin
                        open_count--;
                        text_active = frames[open_count].active;
                        else_ok     = frames[open_count].else_ok;
                    end
                end
                default: ;
            endcase
            res.active     = text_active;
            res.depth      = open_count[DEPTH_OUT_W-1:0];
            res.error_code = err;
            owed_results.push_back(res);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t exp_res;
            got = data[$bits(result_t)-1:0];
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: active %0d depth %0d error_code %0d",
                       got.active, got.depth, got.error_code);
                failures++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (got.active !== exp_res.active)
            begin
                $error("active: expected %0d, got %0d", exp_res.active, got.active);
                failures++;
            end
            if (got.depth !== exp_res.depth)
            begin
                $error("depth: expected %0d, got %0d", exp_res.depth, got.depth);
                failures++;
            end
            if (got.error_code !== exp_res.error_code)
            begin
                $error("error_code: expected %0d, got %0d",
                       exp_res.error_code, got.error_code);
                failures++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    nesting_scoreboard sb = new();

    bit          sender_idle_on;
    bit          sink_idle_on;
    bit          long_hold_req;
    int unsigned stall_left;
    int unsigned cycle_count;

    conditional_nesting_tracker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("conditional_nesting_tracker regression: fail");
        $finish;
    end

    // result side: check accepted results, stall in bursts or one long hold
    initial
    begin
        m_axis_tready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // offer one request and wait for its handshake
    task automatic send_directive(input logic [2:0] op, input bit cond, input bit defd,
                                  input bit polarity);
        if (sender_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, polarity, defd, cond, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_directive(op, cond, defd, polarity);
    endtask

    // hold off new requests until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // one random request, mostly well-formed nesting with some noise
    task automatic send_random(input int unsigned open_bias);
        logic [2:0]  op;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            op = 3'($urandom_range(0, OP_RESERVED_HI));
        else if (sb.open_count == 0)
            op = $urandom_range(0, 1) ? OP_IFDEF : OP_IF;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < open_bias)
                op = $urandom_range(0, 1) ? OP_IFDEF : OP_IF;
            else if (sb.else_ok && roll < open_bias + (100 - open_bias) / 2)
                op = ($urandom_range(0, 3) == 0) ? OP_ELSE : OP_ELIF;
            else
                op = OP_ENDIF;
        end
        send_directive(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
    endtask

    // stimulus
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        long_hold_req  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: errors at the outer level, ignored codes
        send_directive(OP_ELIF, 1'b1, 1'b0, 1'b0);
        send_directive(OP_ELSE, 1'b0, 1'b1, 1'b1);
        send_directive(OP_ENDIF, 1'b1, 1'b1, 1'b1);
        send_directive(OP_RESERVED_LO, 1'b1, 1'b1, 1'b1);
        send_directive(OP_RESERVED_HI, 1'b0, 1'b0, 1'b0);
        // taken chain, then elif and else after else
        send_directive(OP_IF, 1'b1, 1'b0, 1'b0);
        send_directive(OP_ELIF, 1'b1, 1'b0, 1'b0);
        send_directive(OP_ELSE, 1'b0, 1'b0, 1'b0);
        send_directive(OP_ELIF, 1'b1, 1'b0, 1'b0);
        send_directive(OP_ELSE, 1'b0, 1'b0, 1'b0);
        send_directive(OP_ENDIF, 1'b0, 1'b0, 1'b0);
        // elif chain picking a later branch
        send_directive(OP_IF, 1'b0, 1'b0, 1'b0);
        send_directive(OP_ELIF, 1'b0, 1'b0, 1'b0);
        send_directive(OP_ELIF, 1'b1, 1'b0, 1'b0);
        send_directive(OP_IFDEF, 1'b0, 1'b1, 1'b1);
        send_directive(OP_ENDIF, 1'b0, 1'b0, 1'b0);
        send_directive(OP_ENDIF, 1'b0, 1'b0, 1'b0);
        // ifndef polarity, else of a false branch
        send_directive(OP_IFDEF, 1'b0, 1'b0, 1'b0);
        send_directive(OP_IFDEF, 1'b0, 1'b1, 1'b0);
        send_directive(OP_ELSE, 1'b0, 1'b0, 1'b0);
        send_directive(OP_ENDIF, 1'b0, 1'b0, 1'b0);
        // false ifdef nested inside inactive text stays inactive
        send_directive(OP_IF, 1'b0, 1'b0, 1'b0);
        send_directive(OP_IFDEF, 1'b1, 1'b0, 1'b1);
        send_directive(OP_ENDIF, 1'b0, 1'b0, 1'b0);
        send_directive(OP_ENDIF, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // shallow nesting with idling on both sides
        repeat (200) send_random(45);

        // long result stall while requests keep coming
        sender_idle_on = 1'b0;
        long_hold_req  = 1'b1;
        repeat (20) send_random(50);
        sender_idle_on = 1'b1;

        // deep nesting, reaching the full stack and overflow
        repeat (200) send_random(80);
        wait_drained();

        // unwind and stay shallow
        repeat (100) send_random(30);

        // closing stretch with no idling
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        repeat (100) send_random(55);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.failures == 0)
            $display("conditional_nesting_tracker regression: pass");
        else
            $display("conditional_nesting_tracker regression: fail");
        $finish;
    end

endmodule
